// ----- sv/dhtd_pkg.sv -----
`default_nettype none
package dhtd_pkg;

    // Frame geometry
    localparam int TOTAL_EDGES    = 42;
    localparam int PREAMBLE_EDGES = 2;
    localparam int DATA_BITS      = 40;
    localparam int EDGE_CNT_W     = 6;
    localparam int RAW_BITS       = (TOTAL_EDGES > PREAMBLE_EDGES) ?
                                    (TOTAL_EDGES - PREAMBLE_EDGES) : 0;
    localparam int GOT_BITS       = (RAW_BITS > DATA_BITS) ? DATA_BITS : RAW_BITS;
    localparam int PAD_BITS       = DATA_BITS - GOT_BITS;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] CFG_IDX_SENSOR_KIND   = 2'd0;
    localparam logic [1:0] CFG_IDX_ONE_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_IDX_RETRY_LIMIT   = 2'd2;

    localparam logic       RST_SENSOR_KIND   = 1'b1;
    localparam logic [7:0] RST_ONE_THRESHOLD = 8'd100;
    localparam logic [7:0] RST_RETRY_LIMIT   = 8'd5;

    // Input op codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_EDGE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_EDGE  = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_TIMEOUT  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] edge_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
    } t_out_item;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] edge_time;
    } t_cmd_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic       sensor_kind;
        logic [7:0] one_threshold;
        logic [7:0] retry_limit;
    } t_cfg;

endpackage
`default_nettype wire

// ----- sv/dhtd_cfg.sv -----
`default_nettype none
module dhtd_cfg
    import dhtd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_kind   <= RST_SENSOR_KIND;
            r_cfg.one_threshold <= RST_ONE_THRESHOLD;
            r_cfg.retry_limit   <= RST_RETRY_LIMIT;
        end else if (wr_en) begin
            unique case (reg_idx)
                CFG_IDX_SENSOR_KIND:   r_cfg.sensor_kind   <= pwdata[0];
                CFG_IDX_ONE_THRESHOLD: r_cfg.one_threshold <= pwdata[7:0];
                CFG_IDX_RETRY_LIMIT:   r_cfg.retry_limit   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            CFG_IDX_SENSOR_KIND:   prdata[0]   = r_cfg.sensor_kind;
            CFG_IDX_ONE_THRESHOLD: prdata[7:0] = r_cfg.one_threshold;
            CFG_IDX_RETRY_LIMIT:   prdata[7:0] = r_cfg.retry_limit;
            default:               prdata      = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- sv/dhtd_front.sv -----
`default_nettype none
module dhtd_front
    import dhtd_pkg::*;
(
    input  wire logic      i_in_valid,
    input  t_in_item       i_in_data,
    input  t_q_status      i_q_status,
    output logic           o_in_stall,
    output logic           o_push,
    output t_cmd_item      o_push_data
);

    logic known_op;

    // Classify the request; drop the unused op code
    always_comb begin
        known_op         = 1'b1;
        o_push_data.cmd  = CMD_START;
        unique case (i_in_data.op)
            OP_START: o_push_data.cmd = CMD_START;
            OP_EDGE:  o_push_data.cmd = CMD_EDGE;
            OP_TICK:  o_push_data.cmd = CMD_TICK;
            default:  known_op        = 1'b0;
        endcase
    end

    assign o_push_data.edge_time = i_in_data.edge_time;

    // Hold off the producer only while the queue is full
    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full && known_op;

endmodule
`default_nettype wire

// ----- sv/dhtd_queue.sv -----
`default_nettype none
module dhtd_queue
    import dhtd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_cmd_item  i_push_data,
    input  wire logic  i_pop,
    output t_cmd_item  o_pop_data,
    output t_q_status  o_status
);

    t_cmd_item          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_pop_data = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

// ----- sv/dhtd_back.sv -----
`default_nettype none
module dhtd_back
    import dhtd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_cfg       i_cfg,
    input  t_q_status  i_q_status,
    input  t_cmd_item  i_cmd,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output t_out_item  o_out_data
);

    logic [EDGE_CNT_W-1:0] r_edge_count, n_edge_count;
    logic [31:0]           r_last_time,  n_last_time;
    logic [DATA_BITS-1:0]  r_bits,       n_bits;
    logic [7:0]            r_retry_count, n_retry_count;
    logic                  r_armed,      n_armed;
    logic                  r_active,     n_active;
    logic                  r_out_valid;
    t_out_item             r_out_data;

    logic                  go;
    logic                  emit_timeout;
    logic                  emit_frame;
    logic [31:0]           diff;
    logic [7:0]            interval;
    logic                  in_window;
    logic [EDGE_CNT_W-1:0] cnt_inc;
    logic [7:0]            retry_inc;
    logic [DATA_BITS-1:0]  frame;
    logic [7:0]            b0, b1, b2, b3, b4;
    logic [7:0]            sum;
    logic [15:0]           raw_temp;
    t_out_item             frame_item;

    // Retire one command whenever the output register can take a result
    assign go    = !i_q_status.empty && (!r_out_valid || !i_out_stall);
    assign o_pop = go;

    // Edge interval, saturated to eight bits
    assign diff      = i_cmd.edge_time - r_last_time;
    assign interval  = (diff > 32'd255) ? 8'd255 : diff[7:0];
    assign in_window = (int'(r_edge_count) >= PREAMBLE_EDGES) &&
                       (int'(r_edge_count) < PREAMBLE_EDGES + DATA_BITS);
    assign cnt_inc   = r_edge_count + EDGE_CNT_W'(1);
    assign retry_inc = (r_retry_count == 8'd255) ? r_retry_count : r_retry_count + 8'd1;

    // Command execution
    always_comb begin
        n_edge_count  = r_edge_count;
        n_last_time   = r_last_time;
        n_bits        = r_bits;
        n_retry_count = r_retry_count;
        n_armed       = r_armed;
        n_active      = r_active;
        emit_timeout  = 1'b0;
        emit_frame    = 1'b0;
        if (go) begin
            unique case (i_cmd.cmd)
                CMD_START: begin
                    n_retry_count = '0;
                    n_active      = 1'b1;
                    n_armed       = 1'b0;
                end
                CMD_TICK: begin
                    if (r_active) begin
                        n_retry_count = retry_inc;
                        if (retry_inc > i_cfg.retry_limit) begin
                            n_active     = 1'b0;
                            n_armed      = 1'b0;
                            emit_timeout = 1'b1;
                        end else begin
                            n_edge_count = '0;
                            n_bits       = '0;
                            n_last_time  = i_cmd.edge_time;
                            n_armed      = 1'b1;
                        end
                    end
                end
                CMD_EDGE: begin
                    if (r_armed) begin
                        n_last_time  = i_cmd.edge_time;
                        n_edge_count = cnt_inc;
                        if (in_window) begin
                            n_bits = {r_bits[DATA_BITS-2:0],
                                      (interval > i_cfg.one_threshold)};
                        end
                        if (int'(cnt_inc) >= TOTAL_EDGES) begin
                            n_armed    = 1'b0;
                            n_active   = 1'b0;
                            emit_frame = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Unpack the frame, left aligned when the data window is short
    assign frame    = n_bits << PAD_BITS;
    assign b0       = frame[39:32];
    assign b1       = frame[31:24];
    assign b2       = frame[23:16];
    assign b3       = frame[15:8];
    assign b4       = frame[7:0];
    assign sum      = b0 + b1 + b2 + b3;
    assign raw_temp = {b2, b3};

    always_comb begin
        frame_item.status = (sum == b4) ? ST_OK : ST_CHECKSUM;
        if (i_cfg.sensor_kind) begin
            frame_item.humidity = {b0, b1};
            // Sign-magnitude to two's complement; negative zero reads as zero
            if (raw_temp[15]) begin
                frame_item.temperature = 16'h0000 - {1'b0, raw_temp[14:0]};
            end else begin
                frame_item.temperature = raw_temp;
            end
        end else begin
            frame_item.humidity    = {8'h00, b0};
            frame_item.temperature = {8'h00, b2};
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count  <= '0;
            r_last_time   <= '0;
            r_bits        <= '0;
            r_retry_count <= '0;
            r_armed       <= 1'b0;
            r_active      <= 1'b0;
        end else begin
            r_edge_count  <= n_edge_count;
            r_last_time   <= n_last_time;
            r_bits        <= n_bits;
            r_retry_count <= n_retry_count;
            r_armed       <= n_armed;
            r_active      <= n_active;
        end
    end

    // Output register: load a new result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_timeout || emit_frame) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_timeout) begin
            r_out_data.status      <= ST_TIMEOUT;
            r_out_data.humidity    <= '0;
            r_out_data.temperature <= '0;
        end else if (emit_frame) begin
            r_out_data <= frame_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// ----- sv/dht_edge_interval_decoder.sv -----
// Single-wire DHT11/DHT22 reply decoder. Send a start request, then retry
// ticks (each one rearms the capture using its own timestamp) and the
// timestamped falling edges of the line. After the preamble edges, each edge
// interval becomes a data bit, one when it exceeds one_threshold. The last
// frame edge yields one result with humidity, temperature and checksum
// status; a tick that pushes the retry count past retry_limit yields a
// timeout result instead. Requests are accepted while the queue is not full
// and the block sustains one request per cycle while the output does not
// stall: the front decodes the op into a two-entry command queue and the
// back executes one queued command per cycle, when its output register
// can take a result, in its edge/bit datapath and registers the result.
// While a result waits under output stall the back holds, and the queue
// takes up to two more requests before the input stalls. Configure through
// the register port only while no request is in flight.
`default_nettype none
module dht_edge_interval_decoder
    import dhtd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_item               o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    t_cfg      cfg;
    t_q_status q_status;
    t_cmd_item push_data;
    t_cmd_item pop_data;
    logic      push;
    logic      pop;

    dhtd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dhtd_front u_front (
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_q_status  (q_status),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_push_data (push_data)
    );

    dhtd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    dhtd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_status  (q_status),
        .i_cmd       (pop_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
